>>> hw/rtl/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared constants, codes and controller/datapath interface types for the
// Euler totient sieve table.
// ----------------------------------------------------------------------------
package ets_pkg;

   localparam int MAX_N  = 4096;
   localparam int ADDR_W = $clog2(MAX_N + 1);
   localparam int PIDX_W = $clog2(MAX_N);
   localparam int SIZE_W = 13;
   localparam int TOT_W  = 12;
   localparam int CNT_W  = 13;
   localparam int CMP_W  = (ADDR_W > SIZE_W) ? ADDR_W : SIZE_W;
   localparam int PROD_W = 2 * ADDR_W;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

   localparam logic ACT_BUILD = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_UNBUILT = 2'd2;

   typedef struct packed {
      logic init;
      logic clr;
      logic fetch;
      logic check;
      logic prd;
      logic mul;
      logic wr;
      logic adv;
      logic done;
      logic rd;
   } ets_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_small;
      logic i_last;
      logic more;
      logic over;
      logic divides;
   } ets_stat_type;

endpackage

>>> hw/rtl/ets_ctrl.sv
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer for the totient sieve: clearing pass, outer walk over i, inner
// walk over the prime list, and request acceptance.
// ----------------------------------------------------------------------------
module ets_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_action,
   input  ets_pkg::ets_stat_type stat,
   output ets_pkg::ets_cmd_type  cmd,
   output logic                 busy
);
   import ets_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLR,
      S_FETCH,
      S_CHECK,
      S_PRD,
      S_MUL,
      S_WR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_action == ACT_BUILD) begin
                  cmd.init = 1'b1;
                  state_in = stat.n_zero ? S_DONE : S_CLR;
               end else begin
                  cmd.rd = 1'b1;
               end
            end
         end
         S_CLR: begin
            cmd.clr = 1'b1;
            if (stat.i_last) begin
               state_in = stat.n_small ? S_DONE : S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_PRD;
         end
         S_PRD: begin
            if (stat.more) begin
               cmd.prd  = 1'b1;
               state_in = S_MUL;
            end else if (stat.i_last) begin
               state_in = S_DONE;
            end else begin
               cmd.adv  = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            // product past N or p is the least prime factor of i: leave the inner walk
            if (!stat.over) begin
               cmd.wr = 1'b1;
            end
            if (stat.over || stat.divides) begin
               if (stat.i_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.adv  = 1'b1;
                  state_in = S_FETCH;
               end
            end else begin
               state_in = S_PRD;
            end
         end
         S_DONE: begin
            cmd.done = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

>>> hw/rtl/ets_datapath.sv
// ----------------------------------------------------------------------------
// ets_datapath
// Sieve storage (marks, least prime factors, totients, prime list), counters,
// multipliers, configuration register and response registers.
// ----------------------------------------------------------------------------
module ets_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  ets_pkg::ets_cmd_type        cmd,
   output ets_pkg::ets_stat_type       stat,
   input  logic [ets_pkg::SIZE_W-1:0]  req_index,
   input  logic                        csr_we,
   input  logic [ets_pkg::SIZE_W-1:0]  csr_wdata,
   output logic                        rsp_valid,
   output logic [ets_pkg::TOT_W-1:0]   rsp_totient,
   output logic [ets_pkg::CNT_W-1:0]   rsp_prime_count,
   output logic [1:0]                  rsp_status
);
   import ets_pkg::*;

   logic              mark_mem  [0:MAX_N];
   logic [ADDR_W-1:0] lpf_mem   [0:MAX_N];
   logic [ADDR_W-1:0] tot_mem   [0:MAX_N];
   logic [ADDR_W-1:0] plist_mem [0:MAX_N-1];

   logic [SIZE_W-1:0] table_size_ff;
   logic [ADDR_W-1:0] n_ff, n_sat;
   logic [ADDR_W-1:0] i_ff, j_ff, cnt_ff;
   logic [ADDR_W-1:0] limit_ff;
   logic [ADDR_W-1:0] primes_ff;
   logic              built_ff;

   logic              mark_rd_ff;
   logic [ADDR_W-1:0] lpf_rd_ff, tot_rd_ff, plist_rd_ff;
   logic [ADDR_W-1:0] phi_i_ff, lpf_i_ff;
   logic [PROD_W-1:0] m_ff;
   logic [ADDR_W-1:0] prod_ff;
   logic              div_ff;

   logic              rsp_valid_ff, rsp_read_ff;
   logic [1:0]        rsp_status_ff;

   logic              is_prime;
   logic [ADDR_W-1:0] factor;
   logic [PROD_W-1:0] phi_prod;
   logic [ADDR_W-1:0] tot_raddr;
   logic [1:0]        rd_status;

   logic              mark_we, mark_wd, tot_we, lpf_we;
   logic [ADDR_W-1:0] mark_wa, tot_wa, tot_wd;

   assign n_sat = (CMP_W'(table_size_ff) > CMP_W'(MAX_N)) ?
                  ADDR_W'(MAX_N) : ADDR_W'(table_size_ff);

   assign is_prime = !mark_rd_ff && (cnt_ff < ADDR_W'(MAX_N));

   assign stat.n_zero  = (n_sat == '0);
   assign stat.n_small = (n_ff < ADDR_W'(2));
   assign stat.i_last  = (i_ff == n_ff);
   assign stat.more    = (j_ff < cnt_ff);
   assign stat.over    = (m_ff > PROD_W'(n_ff));
   assign stat.divides = div_ff;

   // p divides i exactly when p is the least prime factor of i
   assign factor   = (plist_rd_ff == lpf_i_ff) ? plist_rd_ff : plist_rd_ff - ADDR_W'(1);
   assign phi_prod = PROD_W'(phi_i_ff) * PROD_W'(factor);

   assign tot_raddr = cmd.rd ? ADDR_W'(req_index) : i_ff;

   always_comb begin
      if (!built_ff) begin
         rd_status = ST_UNBUILT;
      end else if ((req_index == '0) || (CMP_W'(req_index) > CMP_W'(limit_ff))) begin
         rd_status = ST_RANGE;
      end else begin
         rd_status = ST_OK;
      end
   end

   always_comb begin
      mark_we = 1'b0;
      mark_wa = i_ff;
      mark_wd = 1'b0;
      tot_we  = 1'b0;
      tot_wa  = i_ff;
      tot_wd  = i_ff - ADDR_W'(1);
      lpf_we  = 1'b0;
      if (cmd.clr) begin
         mark_we = 1'b1;
         tot_we  = (i_ff == ADDR_W'(1));
         tot_wd  = ADDR_W'(1);
      end else if (cmd.check) begin
         tot_we = is_prime;
      end else if (cmd.wr) begin
         mark_we = 1'b1;
         mark_wa = m_ff[ADDR_W-1:0];
         mark_wd = 1'b1;
         tot_we  = 1'b1;
         tot_wa  = m_ff[ADDR_W-1:0];
         tot_wd  = prod_ff;
         lpf_we  = 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (tot_we) begin
         tot_mem[tot_wa] <= tot_wd;
      end
      if (lpf_we) begin
         lpf_mem[mark_wa] <= plist_rd_ff;
      end
      if (cmd.check && is_prime) begin
         plist_mem[cnt_ff[PIDX_W-1:0]] <= i_ff;
      end
      if (cmd.fetch) begin
         mark_rd_ff <= mark_mem[i_ff];
         lpf_rd_ff  <= lpf_mem[i_ff];
      end
      if (cmd.fetch || cmd.rd) begin
         tot_rd_ff <= tot_mem[tot_raddr];
      end
      if (cmd.prd) begin
         plist_rd_ff <= plist_mem[j_ff[PIDX_W-1:0]];
      end
   end

   // sieve payload
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         n_ff <= n_sat;
      end
      if (cmd.check) begin
         phi_i_ff <= is_prime ? i_ff - ADDR_W'(1) : tot_rd_ff;
         lpf_i_ff <= is_prime ? i_ff : lpf_rd_ff;
      end
      if (cmd.mul) begin
         m_ff    <= PROD_W'(i_ff) * PROD_W'(plist_rd_ff);
         prod_ff <= phi_prod[ADDR_W-1:0];
         div_ff  <= (plist_rd_ff == lpf_i_ff);
      end
      if (cmd.init) begin
         i_ff <= ADDR_W'(1);
      end else if (cmd.clr) begin
         i_ff <= stat.i_last ? ADDR_W'(2) : i_ff + ADDR_W'(1);
      end else if (cmd.adv) begin
         i_ff <= i_ff + ADDR_W'(1);
      end
      if (cmd.check) begin
         j_ff <= '0;
      end else if (cmd.wr) begin
         j_ff <= j_ff + ADDR_W'(1);
      end
      if (cmd.init) begin
         cnt_ff <= '0;
      end else if (cmd.check && is_prime) begin
         cnt_ff <= cnt_ff + ADDR_W'(1);
      end
      if (cmd.rd) begin
         rsp_status_ff <= rd_status;
      end else if (cmd.done) begin
         rsp_status_ff <= ST_OK;
      end
      if (cmd.rd || cmd.done) begin
         rsp_read_ff <= cmd.rd;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SIZE_RESET;
         limit_ff      <= '0;
         primes_ff     <= '0;
         built_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            table_size_ff <= csr_wdata;
         end
         if (cmd.done) begin
            limit_ff  <= n_ff;
            primes_ff <= cnt_ff;
            built_ff  <= 1'b1;
         end
         rsp_valid_ff <= cmd.rd || cmd.done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_prime_count = CNT_W'(primes_ff);
   assign rsp_totient     = (rsp_read_ff && (rsp_status_ff == ST_OK)) ?
                            TOT_W'(tot_rd_ff) : '0;

endmodule

>>> hw/rtl/euler_totient_sieve_table.sv
// ----------------------------------------------------------------------------
// euler_totient_sieve_table
// Euler totient table filled by a linear sieve, with single-entry reads.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. req_action selects
//   a build (fill phi(1..N), N from the csr register, capped at the table
//   depth) or a read of phi(req_index).
//   Every request yields exactly one response, shown for one cycle with
//   rsp_valid high; the receiver has no way to hold it off.
//   Reads: response in the cycle after the request; busy stays low, so a read
//   may be issued every cycle. Latency comes from the registered table read.
//   Builds: busy rises the cycle after the request. The build first clears
//   the mark store over 1..N, then fetches and checks each i and walks the
//   prime list: one step per composite marked, plus one for each i whose
//   walk ends on a product past N. Each step reads a prime, multiplies, and
//   writes the entry unless the product is past N.
//   The response shows in the first cycle with busy low again.
//   csr_we writes table_size; write it only while no request is in flight.
//   Reset clears the build status (reads report "not built"), the prime count
//   and sets table_size to 4096. No clearing pass runs at reset.
// ----------------------------------------------------------------------------
module euler_totient_sieve_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [ets_pkg::SIZE_W-1:0]  req_index,
   input  logic                        csr_we,
   input  logic [ets_pkg::SIZE_W-1:0]  csr_wdata,
   output logic                        rsp_valid,
   output logic [ets_pkg::TOT_W-1:0]   rsp_totient,
   output logic [ets_pkg::CNT_W-1:0]   rsp_prime_count,
   output logic [1:0]                  rsp_status
);
   import ets_pkg::*;

   ets_cmd_type  cmd;
   ets_stat_type stat;

   ets_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   ets_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_index       (req_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_totient     (rsp_totient),
      .rsp_prime_count (rsp_prime_count),
      .rsp_status      (rsp_status)
   );

endmodule

>>> hw/rtl/ets_checker.sv
// ----------------------------------------------------------------------------
// ets_checker
// Port-level checks for the totient sieve table, bound to the top level.
// ----------------------------------------------------------------------------
module ets_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_action,
   input logic                        rsp_valid,
   input logic [ets_pkg::TOT_W-1:0]   rsp_totient,
   input logic [ets_pkg::CNT_W-1:0]   rsp_prime_count,
   input logic [1:0]                  rsp_status
);
   import ets_pkg::*;

   // a read answers on the next cycle
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_READ)) |=> rsp_valid)
      else $error("read request without response on next cycle");

   // a build holds the block busy
   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_BUILD)) |=> busy)
      else $error("build request did not raise busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_totient == '0))
      else $error("error response carries a totient");

   a_unbuilt_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_UNBUILT)) |-> (rsp_prime_count == '0))
      else $error("prime count nonzero before any build");

endmodule

bind euler_totient_sieve_table ets_checker u_ets_checker (.*);
